/* hw/rtl/rle_pkg.sv */
// shared types and constants for the byte run-length encoder
// no dependencies

package rle_pkg;

  localparam logic [7:0] RunCap    = 8'd255;
  localparam logic [7:0] MinPacked = 8'd4;
  localparam logic [7:0] Marker    = 8'hFF;
  localparam logic [7:0] Escape    = 8'h00;

  // depth of the run queue between front and back
  localparam int unsigned QDepth = 2;

  // one closed run, waiting to be expanded into output bytes
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] len;
    logic       done;   // last run caused by its input beat
    logic       last;   // last run of the stream
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } push_t;

endpackage

/* hw/rtl/rle_in_if.sv */
// input channel of the byte run-length encoder
// no dependencies

interface rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* hw/rtl/rle_out_if.sv */
// output channel of the byte run-length encoder
// no dependencies

interface rle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       item_done;
  logic       stream_end;

  modport source (output valid, output out_byte, output item_done, output stream_end,
                  input ready);
  modport sink   (input valid, input out_byte, input item_done, input stream_end,
                  output ready);
endinterface

/* hw/rtl/rle_front.sv */
// front end: tracks the open run and emits closed runs into the queue
// depends on rle_pkg, rle_in_if

module rle_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  rle_in_if.sink            in_ch_i,
  input  logic              full_i,
  output rle_pkg::push_t    push_o
);

  logic [7:0]     val_q, len_q;
  logic           pend_q;
  rle_pkg::desc_t pend_desc_q;

  logic           accept, cont, has_old, has_new;
  logic [7:0]     new_len;
  rle_pkg::desc_t old_desc, new_desc;

  always_comb begin
    in_ch_i.ready = !pend_q && !full_i;
    accept  = in_ch_i.valid && in_ch_i.ready;
    cont    = (len_q != 8'd0) && (in_ch_i.in_byte == val_q) && (len_q < rle_pkg::RunCap);
    new_len = cont ? len_q + 8'd1 : 8'd1;
    has_old = !cont && (len_q != 8'd0);
    // cap close and stream end close the new run; they never both add a run
    has_new = (new_len == rle_pkg::RunCap) || in_ch_i.in_last;

    old_desc.value = val_q;
    old_desc.len   = len_q;
    old_desc.done  = !has_new;
    old_desc.last  = 1'b0;

    new_desc.value = in_ch_i.in_byte;
    new_desc.len   = new_len;
    new_desc.done  = 1'b1;
    new_desc.last  = in_ch_i.in_last;

    if (pend_q) begin
      push_o.valid = !full_i;
      push_o.desc  = pend_desc_q;
    end else begin
      push_o.valid = accept && (has_old || has_new);
      push_o.desc  = has_old ? old_desc : new_desc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= 8'd0;
      len_q  <= 8'd0;
      pend_q <= 1'b0;
    end else if (accept) begin
      if (has_new) begin
        len_q <= 8'd0;
        val_q <= in_ch_i.in_last ? 8'd0 : in_ch_i.in_byte;
      end else begin
        len_q <= new_len;
        val_q <= in_ch_i.in_byte;
      end
      pend_q <= has_old && has_new;
    end else if (pend_q && !full_i) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_desc_q <= new_desc;
    end
  end

endmodule

/* hw/rtl/rle_queue.sv */
// short run queue between front and back
// depends on rle_pkg

module rle_queue #(
  parameter int unsigned Depth = rle_pkg::QDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rle_pkg::push_t push_i,
  output logic           full_o,
  output logic           head_valid_o,
  output rle_pkg::desc_t head_o,
  input  logic           pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rle_pkg::desc_t        mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       cnt_q;
  logic                  do_push, do_pop;

  always_comb begin
    full_o       = (cnt_q == CntW'(Depth));
    head_valid_o = (cnt_q != '0);
    head_o       = mem_q[rd_ptr_q];
    do_push      = push_i.valid && !full_o;
    do_pop       = pop_i && head_valid_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.desc;
    end
  end

endmodule

/* hw/rtl/rle_back.sv */
// back end: expands each queued run into output beats
// depends on rle_pkg, rle_out_if

module rle_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  rle_pkg::desc_t head_i,
  output logic           pop_o,
  rle_out_if.source      out_ch_o
);

  logic [2:0] idx_q;
  logic       valid_q, done_q, end_q;
  logic [7:0] byte_q;

  logic       packed_run, esc, is_last, load;
  logic [2:0] total;
  logic [7:0] cur_byte;

  always_comb begin
    packed_run = (head_i.len >= rle_pkg::MinPacked);
    esc        = (head_i.value == rle_pkg::Marker);
    if (packed_run) begin
      total = 3'd3;
    end else if (esc) begin
      total = {head_i.len[1:0], 1'b0};
    end else begin
      total = {1'b0, head_i.len[1:0]};
    end
    is_last = (idx_q == total - 3'd1);

    if (packed_run) begin
      if (idx_q == 3'd0) begin
        cur_byte = rle_pkg::Marker;
      end else if (idx_q == 3'd1) begin
        cur_byte = head_i.len;
      end else begin
        cur_byte = head_i.value;
      end
    end else begin
      // escaped literal: odd positions carry the escape byte
      cur_byte = (esc && idx_q[0]) ? rle_pkg::Escape : head_i.value;
    end

    load  = head_valid_i && (!valid_q || out_ch_o.ready);
    pop_o = load && is_last;

    out_ch_o.valid      = valid_q;
    out_ch_o.out_byte   = byte_q;
    out_ch_o.item_done  = done_q;
    out_ch_o.stream_end = end_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
    end else if (out_ch_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= cur_byte;
      done_q <= head_i.done && is_last;
      end_q  <= head_i.last && is_last;
    end
  end

endmodule

/* hw/rtl/rle_byte_encoder_unit.sv */
// byte run-length encoder with escaped marker: front, run queue and back
// data path: each closed run is written into the run queue, then expanded into the output register
// throughput: one output beat per cycle while output is ready; one input beat per cycle,
//   except while the queue is full or the stream's last run waits pending behind the old run
// reset: asynchronous, active low; clears the open run, queue and output register
// depends on rle_pkg, rle_in_if, rle_out_if, rle_front, rle_queue, rle_back

module rle_byte_encoder_unit #(
  parameter int unsigned QDepth = rle_pkg::QDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rle_in_if.sink    in_ch_i,
  rle_out_if.source out_ch_o
);

  // closed runs travel as descriptors (value, length, flags) so the front
  // waits on the byte-by-byte expansion in the back only when the queue is full
  rle_pkg::push_t push;
  rle_pkg::desc_t head;
  logic           full, head_valid, pop;

  // front: run tracking, closes runs on change, cap and stream end
  rle_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch_i),
    .full_i  (full),
    .push_o  (push)
  );

  // queue: lets the front keep taking beats while a long expansion drains
  rle_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // back: marker/count/value or literals with escapes, into the output register
  rle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_ch_o     (out_ch_o)
  );

endmodule

/* hw/rtl/rle_checker.sv */
// port-level checks for the byte run-length encoder
// depends on rle_byte_encoder_unit (attached by bind)

module rle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       item_done_i,
  input logic       stream_end_i
);

  // a held beat keeps valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  // a held beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(item_done_i)
                                    && $stable(stream_end_i))
    else $error("output payload changed while stalled");

  // stream end always closes the beat's group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stream_end_i |-> item_done_i)
    else $error("stream end without item done");

  // nothing is shown after reset is sampled active
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind rle_byte_encoder_unit rle_checker u_rle_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_ch_o.valid),
  .out_ready_i  (out_ch_o.ready),
  .out_byte_i   (out_ch_o.out_byte),
  .item_done_i  (out_ch_o.item_done),
  .stream_end_i (out_ch_o.stream_end)
);
